// ===== rtl/lpm_pkg.sv =====
// package: types, constants and helpers shared by the route lookup block
`timescale 1ns / 1ps

package lpm_pkg;

    localparam int ROUTE_ENTRIES_DEF = 16;

    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 6;
    localparam int PORT_W      = 3;
    localparam int SLOT_W      = 4;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [LEN_W-1:0] FULL_LEN          = 6'd32;
    localparam logic [LEN_W-1:0] MIN_MATCH_LEN_RST = 6'd24;

    // word select bit value (paddr[2]) that selects the min_match_len register
    localparam logic REG_MIN_MATCH_LEN = 1'b0;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } lpm_state_t;

    typedef struct packed {
        logic              opcode;
        logic [SLOT_W-1:0] entry_index;
        logic              entry_valid;
        logic [ADDR_W-1:0] entry_prefix;
        logic [LEN_W-1:0]  entry_prefix_len;
        logic [ADDR_W-1:0] entry_gateway;
        logic [PORT_W-1:0] entry_port;
        logic [ADDR_W-1:0] lookup_addr;
    } lpm_in_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] match_index;
        logic [LEN_W-1:0]  match_len;
        logic [ADDR_W-1:0] next_hop;
        logic [PORT_W-1:0] out_port;
    } lpm_out_t;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } route_entry_t;

    // leading ones mask, len in 0..32
    function automatic logic [ADDR_W-1:0] len_to_mask(input logic [LEN_W-1:0] len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

// ===== rtl/longest_prefix_match_lookup.sv =====
// longest prefix match lookup: route table, scan sequencer and config register
// route writes are taken while idle; a lookup scans the whole table, reading one entry per cycle
// through the single memory read port, and returns its result through the output register
// the sequencer is idle again with the result, so a new lookup is taken only after the last one
// a result waiting in the output register holds back only the next lookup's finish step
// reset clears all route valid bits and sets min_match_len to 24; table contents are not cleared
`timescale 1ns / 1ps

module longest_prefix_match_lookup
    import lpm_pkg::*;
#(
    parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  req_valid,
    output logic                  req_ready,
    input  lpm_in_t               req,

    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output lpm_out_t              rsp,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ROUTE_ENTRIES);

    lpm_state_t               state_reg, state_next;
    logic [ROUTE_ENTRIES-1:0] route_valid_reg, route_valid_next;
    logic [LEN_W-1:0]         min_len_reg;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic                     have_reg, have_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    logic [ADDR_W-1:0]        addr_reg, addr_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [LEN_W-1:0]         best_len_reg, best_len_next;
    logic [ADDR_W-1:0]        best_gw_reg, best_gw_next;
    logic [PORT_W-1:0]        best_port_reg, best_port_next;
    lpm_out_t                 rsp_reg, rsp_next;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    route_entry_t             wr_data;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    route_entry_t             rd_data;
    logic                     entry_hit;
    logic                     cfg_write;

    lpm_route_ram #(
        .DEPTH (ROUTE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MIN_MATCH_LEN);
    assign prdata    = (paddr[2] == REG_MIN_MATCH_LEN) ?
                       APB_DATA_W'(min_len_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_MATCH_LEN_RST;
        end
        else if (cfg_write)
        begin
            min_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign wr_addr = IDX_W'(req.entry_index);
    assign rd_addr = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        wr_data.prefix  = req.entry_prefix;
        wr_data.len     = (req.entry_prefix_len > FULL_LEN) ? FULL_LEN : req.entry_prefix_len;
        wr_data.gateway = req.entry_gateway;
        wr_data.port    = req.entry_port;
    end

    // entry read last cycle is valid, matches the address and beats the best so far
    assign entry_hit = rd_vld_reg && route_valid_reg[rd_idx_reg]
                       && (((addr_reg ^ rd_data.prefix) & len_to_mask(rd_data.len)) == '0)
                       && (!have_reg || (rd_data.len > best_len_reg));

    always_comb
    begin
        state_next       = state_reg;
        route_valid_next = route_valid_reg;
        cnt_next         = cnt_reg;
        have_next        = have_reg;
        addr_next        = addr_reg;
        best_idx_next    = best_idx_reg;
        best_len_next    = best_len_reg;
        best_gw_next     = best_gw_reg;
        best_port_next   = best_port_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        wr_en            = 1'b0;
        rd_en            = 1'b0;

        if (entry_hit)
        begin
            have_next      = 1'b1;
            best_idx_next  = rd_idx_reg;
            best_len_next  = rd_data.len;
            best_gw_next   = rd_data.gateway;
            best_port_next = rd_data.port;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.opcode == OP_LOOKUP)
                    begin
                        addr_next  = req.lookup_addr;
                        cnt_next   = '0;
                        have_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                    else if (32'(req.entry_index) < ROUTE_ENTRIES)
                    begin
                        // removal only drops the valid bit, stored fields are kept
                        route_valid_next[wr_addr] = req.entry_valid;
                        wr_en = req.entry_valid;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg < CNT_END)
                begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (rd_vld_reg)
                begin
                    // last entry is compared this cycle
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    if (have_reg && (best_len_reg >= min_len_reg))
                    begin
                        rsp_next.found       = 1'b1;
                        rsp_next.match_index = SLOT_W'(best_idx_reg);
                        rsp_next.match_len   = best_len_reg;
                        rsp_next.next_hop    = best_gw_reg;
                        rsp_next.out_port    = best_port_reg;
                    end
                    else
                    begin
                        rsp_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_vld_next = rd_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            route_valid_reg <= '0;
            cnt_reg         <= '0;
            rd_vld_reg      <= 1'b0;
            have_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            route_valid_reg <= route_valid_next;
            cnt_reg         <= cnt_next;
            rd_vld_reg      <= rd_vld_next;
            have_reg        <= have_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_addr;
        addr_reg      <= addr_next;
        best_idx_reg  <= best_idx_next;
        best_len_reg  <= best_len_next;
        best_gw_reg   <= best_gw_next;
        best_port_reg <= best_port_next;
        rsp_reg       <= rsp_next;
    end

endmodule

// ===== rtl/lpm_route_ram.sv =====
// route table storage: one write port, one read port with registered read data
`timescale 1ns / 1ps

module lpm_route_ram
    import lpm_pkg::*;
#(
    parameter int DEPTH = ROUTE_ENTRIES_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  route_entry_t     wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output route_entry_t     rd_data
);

    route_entry_t mem [DEPTH];
    route_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/sv/lpm_route_checker.sv =====
// route lookup checker: predicts every lookup result from the observed transactions and compares
`timescale 1ns / 1ps

module lpm_route_checker
    import lpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  req_valid,
    input  logic                  req_ready,
    input  lpm_in_t               req,

    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  lpm_out_t              rsp,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,

    output int                    mismatches,
    output int                    pending,
    output int                    lookups_seen,
    output int                    hits_seen
);

    localparam int SLOTS = ROUTE_ENTRIES_DEF;
    localparam logic [APB_ADDR_W-1:0] MIN_LEN_ADDR = {REG_MIN_MATCH_LEN, 2'b00};

    logic [LEN_W-1:0]  min_len;
    logic              installed [SLOTS];
    logic [ADDR_W-1:0] pfx       [SLOTS];
    logic [LEN_W-1:0]  plen      [SLOTS];
    logic [ADDR_W-1:0] gw        [SLOTS];
    logic [PORT_W-1:0] oport     [SLOTS];

    lpm_out_t result_q[$];
    int       fail_total;
    int       lookup_total;
    int       hit_total;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] n);
        if (n == 0)
            return '0;
        return {ADDR_W{1'b1}} << (ADDR_W - n);
    endfunction

    // longest valid match wins, first slot scanned keeps a tie
    function automatic lpm_out_t best_route(input logic [ADDR_W-1:0] addr);
        lpm_out_t         r;
        logic             have;
        int               best;
        logic [LEN_W-1:0] blen;
        r    = '0;
        have = 1'b0;
        best = 0;
        blen = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (installed[i] && ((addr ^ pfx[i]) & prefix_mask(plen[i])) == '0
                && (!have || plen[i] > blen))
            begin
                have = 1'b1;
                best = i;
                blen = plen[i];
            end
        end
        if (have && blen >= min_len)
        begin
            r.found       = 1'b1;
            r.match_index = best[SLOT_W-1:0];
            r.match_len   = blen;
            r.next_hop    = gw[best];
            r.out_port    = oport[best];
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        fail_total++;
        if (fail_total <= 10)
            $display("%0t mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        lpm_out_t want;
        int       idx;
        if (!rst_n)
        begin
            min_len = MIN_MATCH_LEN_RST;
            for (int i = 0; i < SLOTS; i++)
                installed[i] = 1'b0;
            result_q.delete();
            fail_total   = 0;
            lookup_total = 0;
            hit_total    = 0;
            mismatches   <= 0;
            pending      <= 0;
            lookups_seen <= 0;
            hits_seen    <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (result_q.size() == 0)
                    note_mismatch($sformatf("result transaction with nothing expected (found=%0d)",
                        rsp.found));
                else
                begin
                    want = result_q.pop_front();
                    lookup_total++;
                    if (want.found)
                        hit_total++;
                    if (rsp.found !== want.found || rsp.match_index !== want.match_index
                        || rsp.match_len !== want.match_len || rsp.next_hop !== want.next_hop
                        || rsp.out_port !== want.out_port)
                        note_mismatch($sformatf(
                            "exp found=%0d slot=%0d len=%0d hop=%h port=%0d, got %0d %0d %0d %h %0d",
                            want.found, want.match_index, want.match_len, want.next_hop,
                            want.out_port, rsp.found, rsp.match_index, rsp.match_len,
                            rsp.next_hop, rsp.out_port));
                end
            end

            if (req_valid && req_ready)
            begin
                idx = int'(req.entry_index);
                if (req.opcode == OP_LOOKUP)
                    result_q.push_back(best_route(req.lookup_addr));
                else if (idx < SLOTS)
                begin
                    // a removal only drops the valid bit, the rest of the slot stays
                    if (!req.entry_valid)
                        installed[idx] = 1'b0;
                    else
                    begin
                        installed[idx] = 1'b1;
                        pfx[idx]       = req.entry_prefix;
                        plen[idx]      = (req.entry_prefix_len > FULL_LEN) ? FULL_LEN
                                                                           : req.entry_prefix_len;
                        gw[idx]        = req.entry_gateway;
                        oport[idx]     = req.entry_port;
                    end
                end
            end

            if (psel && penable && pready && paddr == MIN_LEN_ADDR)
            begin
                if (pwrite)
                    min_len = pwdata[LEN_W-1:0];
                else if (prdata !== {{(APB_DATA_W-LEN_W){1'b0}}, min_len})
                    note_mismatch($sformatf("min_match_len read exp %0d got %h", min_len, prdata));
            end

            mismatches   <= fail_total;
            pending      <= result_q.size();
            lookups_seen <= lookup_total;
            hits_seen    <= hit_total;
        end
    end

endmodule

// ===== tb/sv/tb_longest_prefix_match_lookup.sv =====
// testbench top: route table stimulus, config sequencing and the verdict for the lookup block
`timescale 1ns / 1ps

module tb_longest_prefix_match_lookup;
    import lpm_pkg::*;

    localparam int SLOTS            = ROUTE_ENTRIES_DEF;
    localparam int LOOKUP_CYCLES    = SLOTS + 2;
    localparam int RANDOM_PER_PHASE = 220;
    localparam logic [APB_ADDR_W-1:0] MIN_LEN_ADDR = {REG_MIN_MATCH_LEN, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    lpm_in_t               req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    lpm_out_t              rsp;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fails;
    int pending;
    int lookups_seen;
    int hits_seen;

    // generator-side view of the table, only used to aim addresses at installed routes
    logic              gen_on  [SLOTS];
    logic [ADDR_W-1:0] gen_pfx [SLOTS];
    int                gen_len [SLOTS];
    int                sent;
    int                burst_left;
    int                settings_used;

    longest_prefix_match_lookup #(
        .ROUTE_ENTRIES(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    lpm_route_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .mismatches(fails),
        .pending(pending),
        .lookups_seen(lookups_seen),
        .hits_seen(hits_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results outstanding", pending);
        $display("Verification failed");
        $finish;
    end

    // result side: each span picks a stall style of its own
    initial
    begin : result_stall
        int mode;
        int span;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(40, 300);
            for (int c = 0; c < span; c++)
            begin
                @(posedge clk);
                case (mode)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= ($urandom_range(0, 3) != 0);
                    2: rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= ((c % 24) >= 20);
                endcase
            end
        end
    end

    function automatic logic [ADDR_W-1:0] lead_mask(input int n);
        if (n == 0)
            return '0;
        return {ADDR_W{1'b1}} << (ADDR_W - n);
    endfunction

    function automatic lpm_in_t noise_item();
        lpm_in_t it;
        it.opcode           = 1'($urandom_range(0, 1));
        it.entry_index      = SLOT_W'($urandom_range(0, SLOTS - 1));
        it.entry_valid      = 1'($urandom_range(0, 1));
        it.entry_prefix     = $urandom;
        it.entry_prefix_len = LEN_W'($urandom_range(0, 63));
        it.entry_gateway    = $urandom;
        it.entry_port       = PORT_W'($urandom_range(0, 7));
        it.lookup_addr      = $urandom;
        return it;
    endfunction

    function automatic int pick_live();
        int cand[$];
        for (int i = 0; i < SLOTS; i++)
            if (gen_on[i])
                cand.push_back(i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // sender bursts: a random gap opens each burst, some bursts start with none
    task automatic issue(input lpm_in_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req       <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sent++;
    endtask

    task automatic write_route(input int slot, input logic [ADDR_W-1:0] prefix, input int len,
                               input logic [ADDR_W-1:0] gateway, input int port);
        lpm_in_t it;
        it                  = noise_item();
        it.opcode           = OP_WRITE;
        it.entry_index      = slot[SLOT_W-1:0];
        it.entry_valid      = 1'b1;
        it.entry_prefix     = prefix;
        it.entry_prefix_len = len[LEN_W-1:0];
        it.entry_gateway    = gateway;
        it.entry_port       = port[PORT_W-1:0];
        gen_on[slot]  = 1'b1;
        gen_pfx[slot] = prefix;
        gen_len[slot] = (len > 32) ? 32 : len;
        issue(it);
    endtask

    task automatic drop_route(input int slot);
        lpm_in_t it;
        it             = noise_item();
        it.opcode      = OP_WRITE;
        it.entry_index = slot[SLOT_W-1:0];
        it.entry_valid = 1'b0;
        gen_on[slot]   = 1'b0;
        issue(it);
    endtask

    task automatic lookup(input logic [ADDR_W-1:0] addr);
        lpm_in_t it;
        it             = noise_item();
        it.opcode      = OP_LOOKUP;
        it.lookup_addr = addr;
        issue(it);
    endtask

    // drain, let the sequencer go idle, then write and read back min_match_len
    task automatic set_min_len(input int value);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LOOKUP_CYCLES + 2) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MIN_LEN_ADDR;
        pwdata  <= {26'($urandom), value[LEN_W-1:0]};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        burst_left = 0;
        settings_used++;
    endtask

    task automatic random_item();
        int                r;
        int                q;
        int                s;
        int                live;
        int                base;
        int                slot;
        int                len;
        logic [ADDR_W-1:0] m;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] addr;
        r = $urandom_range(0, 99);
        if (r < 24)
        begin
            slot = $urandom_range(0, SLOTS - 1);
            base = pick_live();
            s    = $urandom_range(0, 9);
            if (base >= 0 && s < 4)
            begin
                // more specific route nested under an installed one
                len    = $urandom_range(gen_len[base], 32);
                m      = lead_mask(gen_len[base]);
                prefix = (gen_pfx[base] & m) | ($urandom & ~m);
            end
            else if (base >= 0 && s < 5)
            begin
                prefix = gen_pfx[base];
                len    = gen_len[base];
            end
            else
            begin
                prefix = $urandom;
                if (s < 8)
                    len = $urandom_range(16, 32);
                else if (s < 9)
                    len = $urandom_range(0, 15);
                else
                    len = $urandom_range(33, 63);
            end
            write_route(slot, prefix, len, $urandom, $urandom_range(0, 7));
        end
        else if (r < 31)
        begin
            live = pick_live();
            drop_route((live >= 0) ? live : $urandom_range(0, SLOTS - 1));
        end
        else
        begin
            live = pick_live();
            q    = $urandom_range(0, 9);
            if (live >= 0 && q < 6)
            begin
                m    = lead_mask(gen_len[live]);
                addr = (gen_pfx[live] & m) | ($urandom & ~m);
            end
            else if (live >= 0 && q < 7)
                addr = gen_pfx[live];
            else
                addr = $urandom;
            lookup(addr);
        end
    endtask

    initial
    begin : stimulus
        int phase_min [7];
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        sent          = 0;
        burst_left    = 0;
        settings_used = 1;
        for (int i = 0; i < SLOTS; i++)
        begin
            gen_on[i]  = 1'b0;
            gen_pfx[i] = '0;
            gen_len[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed: empty table, ties, saturated and zero lengths, removal, min extremes
        lookup(32'hC0A8_0101);
        write_route(0, 32'hC0A8_0100, 24, 32'h0A00_0001, 1);
        write_route(15, 32'hC0A8_0101, 32, 32'hFFFF_FFFF, 7);
        lookup(32'hC0A8_0101);
        lookup(32'hC0A8_01FE);
        write_route(3, 32'hC0A8_01FF, 24, 32'h0A00_0003, 2);
        lookup(32'hC0A8_0177);
        write_route(5, 32'hFFFF_FFFF, 63, 32'h1234_5678, 5);
        lookup(32'hFFFF_FFFF);
        write_route(7, 32'hDEAD_BEEF, 0, 32'hAAAA_AAAA, 6);
        lookup(32'h0000_0000);
        write_route(9, 32'h0A00_0000, 8, 32'h0102_0304, 4);
        lookup(32'h0A7F_0000);
        drop_route(0);
        lookup(32'hC0A8_0177);
        write_route(1, 32'h0000_0000, 32, 32'h0000_0000, 0);
        lookup(32'h0000_0000);
        lookup(32'hC0A9_0001);
        set_min_len(0);
        lookup(32'h0A0B_0C0D);
        lookup(32'h0100_0000);
        set_min_len(63);
        lookup(32'hFFFF_FFFF);
        set_min_len(32);
        lookup(32'hC0A8_0101);
        lookup(32'hC0A8_0102);

        phase_min = '{0, 32, $urandom_range(1, 31), 63, $urandom_range(33, 62),
                      $urandom_range(8, 28), 24};
        foreach (phase_min[p])
        begin
            set_min_len(phase_min[p]);
            repeat (RANDOM_PER_PHASE) random_item();
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2 * LOOKUP_CYCLES) @(posedge clk);

        $display("run covered %0d transactions over %0d min_match_len settings", sent,
                 settings_used);
        $display("%0d lookup results checked, %0d hits, %0d mismatches", lookups_seen,
                 hits_seen, fails);
        if (fails == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lpm_pkg.sv
rtl/lpm_route_ram.sv
rtl/longest_prefix_match_lookup.sv
tb/sv/lpm_route_checker.sv
tb/sv/tb_longest_prefix_match_lookup.sv
